@@ hdl/mck_pkg.sv @@
`timescale 1ns / 1ps

package mck_pkg;

  localparam int MAX_SYMBOLS_DEF = 6;
  localparam int CODE_W          = 6;   // longest code in the table
  localparam int LEN_W           = 3;
  localparam int IDX_W           = 6;
  localparam int CFG_IDX_W       = 8;
  localparam int TIME_W          = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DOT        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_GAP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 8'd3;

  localparam logic [TIME_W-1:0] DOT_RESET         = 16'd100;
  localparam logic [TIME_W-1:0] DASH_RESET        = 16'd300;
  localparam logic [TIME_W-1:0] ELEMENT_GAP_RESET = 16'd100;
  localparam logic [TIME_W-1:0] LETTER_GAP_RESET  = 16'd300;

  localparam logic [IDX_W-1:0] IDX_PERIOD     = 6'd36;
  localparam logic [IDX_W-1:0] IDX_COMMA      = 6'd37;
  localparam logic [IDX_W-1:0] IDX_UNDERSCORE = 6'd38;
  localparam logic [IDX_W-1:0] IDX_COLON      = 6'd39;
  localparam logic [IDX_W-1:0] IDX_QUESTION   = 6'd40;
  localparam logic [IDX_W-1:0] IDX_MINUS      = 6'd41;
  localparam logic [IDX_W-1:0] IDX_EQUALS     = 6'd42;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SYM,
    ST_GAP,
    ST_LGAP
  } state_t;

  // pat is left aligned: bit CODE_W-1 is the first symbol, 1 = dash
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] pat;
  } code_t;

  function automatic logic [IDX_W-1:0] code_index(input logic [7:0] ch);
    logic [IDX_W-1:0] idx;
    idx = IDX_QUESTION;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      idx = IDX_W'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      idx = IDX_W'(ch - 8'h41 + 8'd10);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      idx = IDX_W'(ch - 8'h61 + 8'd10);
    end else begin
      case (ch)
        8'h2E:        idx = IDX_PERIOD;
        8'h2C:        idx = IDX_COMMA;
        8'h5F, 8'h20: idx = IDX_UNDERSCORE;
        8'h3A:        idx = IDX_COLON;
        8'h2D:        idx = IDX_MINUS;
        8'h3D:        idx = IDX_EQUALS;
        default:      idx = IDX_QUESTION;
      endcase
    end
    return idx;
  endfunction

  function automatic code_t code_lookup(input logic [IDX_W-1:0] idx);
    code_t c;
    case (idx)
      6'd0:  c = '{3'd5, 6'b111110};
      6'd1:  c = '{3'd5, 6'b011110};
      6'd2:  c = '{3'd5, 6'b001110};
      6'd3:  c = '{3'd5, 6'b000110};
      6'd4:  c = '{3'd5, 6'b000010};
      6'd5:  c = '{3'd5, 6'b000000};
      6'd6:  c = '{3'd5, 6'b100000};
      6'd7:  c = '{3'd5, 6'b110000};
      6'd8:  c = '{3'd5, 6'b111000};
      6'd9:  c = '{3'd5, 6'b111100};
      6'd10: c = '{3'd2, 6'b010000};
      6'd11: c = '{3'd4, 6'b100000};
      6'd12: c = '{3'd4, 6'b101000};
      6'd13: c = '{3'd3, 6'b100000};
      6'd14: c = '{3'd1, 6'b000000};
      6'd15: c = '{3'd4, 6'b001000};
      6'd16: c = '{3'd3, 6'b110000};
      6'd17: c = '{3'd4, 6'b000000};
      6'd18: c = '{3'd2, 6'b000000};
      6'd19: c = '{3'd4, 6'b011100};
      6'd20: c = '{3'd3, 6'b101000};
      6'd21: c = '{3'd4, 6'b010000};
      6'd22: c = '{3'd2, 6'b110000};
      6'd23: c = '{3'd2, 6'b100000};
      6'd24: c = '{3'd3, 6'b111000};
      6'd25: c = '{3'd4, 6'b011000};
      6'd26: c = '{3'd4, 6'b110100};
      6'd27: c = '{3'd3, 6'b010000};
      6'd28: c = '{3'd3, 6'b000000};
      6'd29: c = '{3'd1, 6'b100000};
      6'd30: c = '{3'd3, 6'b001000};
      6'd31: c = '{3'd4, 6'b000100};
      6'd32: c = '{3'd3, 6'b011000};
      6'd33: c = '{3'd4, 6'b100100};
      6'd34: c = '{3'd4, 6'b101100};
      6'd35: c = '{3'd4, 6'b110000};
      6'd36: c = '{3'd6, 6'b010101};
      6'd37: c = '{3'd6, 6'b110011};
      6'd38: c = '{3'd6, 6'b001101};
      6'd39: c = '{3'd6, 6'b111000};
      6'd41: c = '{3'd6, 6'b100001};
      6'd42: c = '{3'd5, 6'b100010};
      default: c = '{3'd6, 6'b001100};  // question mark
    endcase
    return c;
  endfunction

endpackage

@@ hdl/morse_character_keyer.sv @@
`timescale 1ns / 1ps

// Morse character keyer.
// Input channel (in_valid / in_stall): one request carries an ASCII
// character and more_follow. The character is looked up in the Morse table
// and sent as timed segments on the output channel (out_valid / out_stall):
// key_on = 1 for each dot or dash, key_on = 0 for the element gap between
// symbols and for the letter gap added when more_follow is set.
// last_segment marks the final segment of the character.
// A character of n symbols gives 2n-1 segments, plus one with more_follow,
// so at most 12. The sequencer emits one segment per cycle while the output is
// not stalled, through a single duration select and a symbol shift register.
// The first segment is registered from the symbol state that follows the taken
// request; the input stalls until the last segment is emitted, and the next
// request is taken the cycle after the last segment is registered, even while that segment waits.
// in_stall is high while a character is being sent.
// A stalled output holds its segment; the sequencer waits with it.
// Reset (synchronous) empties the output, returns to idle and loads the
// timing registers with 100/300/100/300 ms. Configuration writes go through
// cfg_we / cfg_index / cfg_data; indexes past the last register are ignored.
module morse_character_keyer #(
  parameter int MAX_SYMBOLS = mck_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mck_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mck_pkg::TIME_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    character,
  input  logic                          more_follow,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          key_on,
  output logic [mck_pkg::TIME_W-1:0]    duration,
  output logic                          last_segment
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int SHIFT = MAX_SYMBOLS - mck_pkg::CODE_W;

  logic [mck_pkg::TIME_W-1:0] dot_time;
  logic [mck_pkg::TIME_W-1:0] dash_time;
  logic [mck_pkg::TIME_W-1:0] element_gap_time;
  logic [mck_pkg::TIME_W-1:0] letter_gap_time;

  mck_pkg::state_t state, state_next;
  logic [MAX_SYMBOLS-1:0] sym, sym_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic                   more, more_next;

  logic                       accept;
  logic                       out_free;
  logic                       emit;
  logic                       seg_on;
  logic                       seg_last;
  logic [mck_pkg::TIME_W-1:0] seg_dur;
  mck_pkg::code_t             code;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_time         <= mck_pkg::DOT_RESET;
      dash_time        <= mck_pkg::DASH_RESET;
      element_gap_time <= mck_pkg::ELEMENT_GAP_RESET;
      letter_gap_time  <= mck_pkg::LETTER_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mck_pkg::REG_DOT:         dot_time         <= cfg_data;
        mck_pkg::REG_DASH:        dash_time        <= cfg_data;
        mck_pkg::REG_ELEMENT_GAP: element_gap_time <= cfg_data;
        mck_pkg::REG_LETTER_GAP:  letter_gap_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != mck_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign code     = mck_pkg::code_lookup(mck_pkg::code_index(character));

  always_comb begin
    state_next = state;
    sym_next   = sym;
    cnt_next   = cnt;
    more_next  = more;
    emit       = 1'b0;
    seg_on     = 1'b0;
    seg_last   = 1'b0;
    seg_dur    = element_gap_time;
    unique case (state)
      mck_pkg::ST_IDLE: begin
        if (accept) begin
          // every code fits in MAX_SYMBOLS, so the length is never clipped
          sym_next   = MAX_SYMBOLS'(code.pat) << SHIFT;
          cnt_next   = CNT_W'(code.len);
          more_next  = more_follow;
          state_next = mck_pkg::ST_SYM;
        end
      end
      mck_pkg::ST_SYM: begin
        seg_on   = 1'b1;
        seg_dur  = sym[MAX_SYMBOLS-1] ? dash_time : dot_time;
        seg_last = (cnt == CNT_W'(1)) && !more;
        if (out_free) begin
          emit     = 1'b1;
          sym_next = sym << 1;
          cnt_next = cnt - CNT_W'(1);
          if (cnt != CNT_W'(1)) begin
            state_next = mck_pkg::ST_GAP;
          end else if (more) begin
            state_next = mck_pkg::ST_LGAP;
          end else begin
            state_next = mck_pkg::ST_IDLE;
          end
        end
      end
      mck_pkg::ST_GAP: begin
        seg_dur = element_gap_time;
        if (out_free) begin
          emit       = 1'b1;
          state_next = mck_pkg::ST_SYM;
        end
      end
      mck_pkg::ST_LGAP: begin
        seg_dur  = letter_gap_time;
        seg_last = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          state_next = mck_pkg::ST_IDLE;
        end
      end
      default: state_next = mck_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mck_pkg::ST_IDLE;
      cnt   <= '0;
      more  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      more  <= more_next;
    end
  end

  always_ff @(posedge clk) begin
    sym <= sym_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      key_on       <= seg_on;
      duration     <= seg_dur;
      last_segment <= seg_last;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("keyer took a request but did not go busy");

  a_gap_then_symbol: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_on && !last_segment) |-> (state == mck_pkg::ST_SYM))
    else $error("element gap not followed by a symbol");

  a_idle_holds_last: assert property (@(posedge clk) disable iff (rst)
    (state == mck_pkg::ST_IDLE && out_valid) |-> last_segment)
    else $error("idle with a pending segment that is not the last");

  a_gap_has_symbols: assert property (@(posedge clk) disable iff (rst)
    (state == mck_pkg::ST_GAP) |-> (cnt != '0))
    else $error("element gap with no symbol left");

endmodule
